### src/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, widths and helpers for the matrix-vector multiplier.
// ----------------------------------------------------------------------------
package mvm_pkg;

  // Element and sum widths
  localparam int VALUE_BITS = 16;
  localparam int PROD_BITS  = 2 * VALUE_BITS;
  localparam int SUM_BITS   = 40;

  // Matrix size limits
  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 4096;
  localparam int COL_BITS  = $clog2(MAX_COLS);
  localparam int ROW_BITS  = $clog2(MAX_ROWS);
  localparam int COLS_REG_BITS = 9;
  localparam int ROWS_REG_BITS = 13;
  localparam int CFG_DATA_BITS = ROWS_REG_BITS;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT = 2'd1;

  // Input item kinds
  localparam logic KIND_VECTOR = 1'b0;
  localparam logic KIND_MATRIX = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  // Configuration as seen by the front end
  typedef struct packed {
    logic [ROWS_REG_BITS-1:0] row_count;
    logic [COLS_REG_BITS-1:0] col_count;
  } mvm_cfg_t;

  // One multiply-accumulate operation
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] mat_val;
    logic signed [VALUE_BITS-1:0] vec_val;
    logic                         row_end;
    logic [ROW_BITS-1:0]          row_index;
    logic                         last_row;
  } mvm_op_t;

  // Effective column count: zero acts as one, saturate at MAX_COLS
  function automatic logic [COLS_REG_BITS-1:0] eff_cols(
    input logic [COLS_REG_BITS-1:0] reg_val
  );
    logic [COLS_REG_BITS-1:0] res;
    if (reg_val == '0) begin
      res = COLS_REG_BITS'(1);
    end else if (reg_val > COLS_REG_BITS'(MAX_COLS)) begin
      res = COLS_REG_BITS'(MAX_COLS);
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

  // Effective row count: zero acts as one, saturate at MAX_ROWS
  function automatic logic [ROWS_REG_BITS-1:0] eff_rows(
    input logic [ROWS_REG_BITS-1:0] reg_val
  );
    logic [ROWS_REG_BITS-1:0] res;
    if (reg_val == '0) begin
      res = ROWS_REG_BITS'(1);
    end else if (reg_val > ROWS_REG_BITS'(MAX_ROWS)) begin
      res = ROWS_REG_BITS'(MAX_ROWS);
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

endpackage

### src/mvm_if.sv
// ----------------------------------------------------------------------------
// mvm_if
// Valid/ready stream interfaces for input items and row results.
// ----------------------------------------------------------------------------

// Input items: vector loads and matrix elements
interface mvm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic signed [mvm_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// Row results
interface mvm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mvm_pkg::SUM_BITS-1:0]  row_sum;
  logic [mvm_pkg::ROW_BITS-1:0]         row_index;
  logic                                 last_row;

  modport source (output valid, output row_sum, output row_index, output last_row,
                  input ready);
  modport sink   (input valid, input row_sum, input row_index, input last_row,
                  output ready);
endinterface

### src/mvm_front.sv
// ----------------------------------------------------------------------------
// mvm_front
// Accepts input beats, keeps the vector store and the column/row positions,
// and hands matrix elements with their vector operand to the queue.
// ----------------------------------------------------------------------------
module mvm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mvm_pkg::mvm_cfg_t cfg_i,
  mvm_in_if.sink            in_i,
  output logic              op_valid_o,
  output mvm_pkg::mvm_op_t  op_o,
  input  logic              op_ready_i
);
  import mvm_pkg::*;

  logic signed [VALUE_BITS-1:0] vec_mem [MAX_COLS];

  logic [COL_BITS-1:0] fill_q, fill_d;
  logic [COL_BITS-1:0] col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;

  logic                         s1_valid_q, s1_valid_d;
  logic signed [VALUE_BITS-1:0] s1_mat_q;
  logic signed [VALUE_BITS-1:0] s1_vec_q;
  logic                         s1_end_q;
  logic [ROW_BITS-1:0]          s1_row_q;
  logic                         s1_last_q;

  logic [COLS_REG_BITS-1:0] cols;
  logic [ROWS_REG_BITS-1:0] rows;
  logic                     accept, vec_beat, mat_beat, s1_free;
  logic                     fill_wrap, col_wrap, row_wrap;

  assign cols = eff_cols(cfg_i.col_count);
  assign rows = eff_rows(cfg_i.row_count);

  // Stage register can take a beat when empty or draining this cycle
  assign s1_free    = !s1_valid_q || op_ready_i;
  assign in_i.ready = s1_free;
  assign accept     = in_i.valid && in_i.ready;
  assign vec_beat   = accept && (in_i.kind == KIND_VECTOR);
  assign mat_beat   = accept && (in_i.kind == KIND_MATRIX);

  // Position wrap tests; a position at or past the count minus one is the last one
  assign fill_wrap = ({1'b0, fill_q} + COLS_REG_BITS'(1)) >= cols;
  assign col_wrap  = ({1'b0, col_q} + COLS_REG_BITS'(1)) >= cols;
  assign row_wrap  = ({1'b0, row_q} + ROWS_REG_BITS'(1)) >= rows;

  // Next positions
  always_comb begin
    fill_d = fill_q;
    col_d  = col_q;
    row_d  = row_q;
    if (vec_beat) begin
      fill_d = fill_wrap ? '0 : fill_q + COL_BITS'(1);
    end
    if (mat_beat) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + ROW_BITS'(1);
      end else begin
        col_d = col_q + COL_BITS'(1);
      end
    end
  end

  // Stage valid
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (op_ready_i) begin
      s1_valid_d = 1'b0;
    end
    if (mat_beat) begin
      s1_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Vector store: write on vector beats, registered read on matrix beats
  always_ff @(posedge clk_i) begin
    if (vec_beat) begin
      vec_mem[fill_q] <= in_i.value;
    end
    if (mat_beat) begin
      s1_vec_q <= vec_mem[col_q];
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (mat_beat) begin
      s1_mat_q  <= in_i.value;
      s1_end_q  <= col_wrap;
      s1_row_q  <= row_q;
      s1_last_q <= row_wrap;
    end
  end

  assign op_valid_o   = s1_valid_q;
  assign op_o.mat_val   = s1_mat_q;
  assign op_o.vec_val   = s1_vec_q;
  assign op_o.row_end   = s1_end_q;
  assign op_o.row_index = s1_row_q;
  assign op_o.last_row  = s1_last_q;

endmodule

### src/mvm_queue.sv
// ----------------------------------------------------------------------------
// mvm_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module mvm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  mvm_pkg::mvm_op_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output mvm_pkg::mvm_op_t pop_data_o,
  input  logic             pop_ready_i
);
  import mvm_pkg::*;

  mvm_op_t entries_q [QUEUE_DEPTH];

  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_BITS:0]   count_q;
  logic                      push, pop;

  assign push_ready_o = count_q != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = entries_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + (QUEUE_PTR_BITS+1)'(1);
        2'b01:   count_q <= count_q - (QUEUE_PTR_BITS+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/mvm_back.sv
// ----------------------------------------------------------------------------
// mvm_back
// Multiplies each queued element pair, accumulates the row sum and holds
// finished row results in an output register.
// ----------------------------------------------------------------------------
module mvm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  input  mvm_pkg::mvm_op_t op_i,
  output logic             op_ready_o,
  mvm_out_if.source        out_o
);
  import mvm_pkg::*;

  // Multiply stage
  logic                        m_valid_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic signed [PROD_BITS-1:0] prod_d;
  logic                        m_end_q;
  logic [ROW_BITS-1:0]         m_row_q;
  logic                        m_last_q;

  // Accumulator and output register
  logic [SUM_BITS-1:0] acc_q, sum_d;
  logic                out_valid_q;
  logic [SUM_BITS-1:0] out_sum_q;
  logic [ROW_BITS-1:0] out_row_q;
  logic                out_last_q;

  logic out_free, m_adv, pop, emit;

  assign out_free   = !out_valid_q || out_o.ready;
  assign m_adv      = m_valid_q && (!m_end_q || out_free);
  assign op_ready_o = !m_valid_q || m_adv;
  assign pop        = op_valid_i && op_ready_o;
  assign emit       = m_adv && m_end_q;

  assign prod_d = op_i.mat_val * op_i.vec_val;
  assign sum_d  = acc_q + {{(SUM_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

  // Control registers and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (op_ready_o) begin
        m_valid_q <= op_valid_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (m_adv) begin
        acc_q <= m_end_q ? '0 : sum_d;
      end
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      prod_q   <= prod_d;
      m_end_q  <= op_i.row_end;
      m_row_q  <= op_i.row_index;
      m_last_q <= op_i.last_row;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_sum_q  <= sum_d;
      out_row_q  <= m_row_q;
      out_last_q <= m_last_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.row_sum   = out_sum_q;
  assign out_o.row_index = out_row_q;
  assign out_o.last_row  = out_last_q;

endmodule

### src/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Streaming Q4.12 matrix-vector multiplier with a Q16.24 row sum output.
// ----------------------------------------------------------------------------
// Takes one input beat per clock with no bubbles, vector loads and matrix
// elements alike, as long as results are taken. Vector beats fill the store in
// column order; matrix beats arrive row-major, and each row produces one result
// beat. A matrix element passes the store read register, the queue, the product
// register and the accumulator; a row result is registered in the output
// register as the row's last element is accumulated. Throughput is set by the
// single 16x16 multiplier and 40-bit accumulator, one element per cycle while
// results are taken. A four-entry queue decouples input acceptance from a
// stalled result port. The vector store holds no reset value: load the vector
// before streaming the matrix. Write row_count and col_count only while idle.
// ----------------------------------------------------------------------------
module matrix_vector_multiply (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mvm_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [mvm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  mvm_in_if.sink                             in_i,
  mvm_out_if.source                          out_o
);
  import mvm_pkg::*;

  mvm_cfg_t cfg_q;
  logic     op_valid, op_ready, q_valid, q_ready;
  mvm_op_t  op, q_op;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count <= ROWS_REG_BITS'(1);
      cfg_q.col_count <= COLS_REG_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_COUNT: cfg_q.row_count <= cfg_wdata_i[ROWS_REG_BITS-1:0];
        REG_COL_COUNT: cfg_q.col_count <= cfg_wdata_i[COLS_REG_BITS-1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  mvm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_ready_i (op_ready)
  );

  mvm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (op_valid),
    .push_data_i  (op),
    .push_ready_o (op_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_op),
    .pop_ready_i  (q_ready)
  );

  mvm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_op),
    .op_ready_o (q_ready),
    .out_o      (out_o)
  );

endmodule

### tb/sv/matrix_vector_multiply_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_test
// Self-checking bench for the streaming Q4.12 matrix-vector multiplier. Vector
// loads and matrix elements are driven over the input stream while an
// in-bench model of the row accumulator predicts each row result. Results are
// compared field by field in arrival order. Directed tests cover reset
// defaults, zero and saturating counts, vector loads inside a row and count
// changes in the middle of a row. Random phases then sweep counts, values and
// back-pressure on both streams.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_test;
  import mvm_pkg::*;

  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_ITEMS    = 350;
  localparam int WIDE_COLS       = 64;
  localparam int WRAP_ROWS       = 3;
  localparam int ROWS_REG_MAX    = 2 ** ROWS_REG_BITS - 1;
  localparam int COLS_REG_MAX    = 2 ** COLS_REG_BITS - 1;
  localparam logic signed [VALUE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] MOST_POSITIVE = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // One predicted row result
  typedef struct {
    logic signed [SUM_BITS-1:0] row_sum;
    logic [ROW_BITS-1:0]        row_index;
    logic                       last_row;
  } row_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  mvm_in_if  in_bus ();
  mvm_out_if out_bus ();

  matrix_vector_multiply i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // Accumulator model state
  logic signed [VALUE_BITS-1:0] vec_mem [MAX_COLS];
  bit                           vec_loaded [MAX_COLS];
  logic [COL_BITS-1:0]          fill_pos;
  logic [COL_BITS-1:0]          col_pos;
  logic [ROW_BITS-1:0]          row_pos;
  logic signed [SUM_BITS-1:0]   acc_sum;
  logic [ROWS_REG_BITS-1:0]     rows_reg;
  logic [COLS_REG_BITS-1:0]     cols_reg;

  row_result_t expected_rows [$];

  bit          idle_on;
  bit          extreme_values;
  int          result_hold;
  int          error_count;
  int unsigned items_sent;

  // Clock
  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count of zero acts as one, large counts saturate
  function automatic int unsigned effective_count(input int unsigned reg_val,
                                                  input int unsigned limit);
    if (reg_val == 0) return 1;
    if (reg_val > limit) return limit;
    return reg_val;
  endfunction

  // Advance the accumulator model by one accepted beat
  function automatic void predict_item(input logic kind,
                                       input logic signed [VALUE_BITS-1:0] value);
    int unsigned                cols;
    int unsigned                rows;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [SUM_BITS-1:0]  prod_wide;
    row_result_t                 res;
    cols = effective_count(cols_reg, MAX_COLS);
    rows = effective_count(rows_reg, MAX_ROWS);
    if (kind == KIND_VECTOR) begin
      vec_mem[fill_pos]    = value;
      vec_loaded[fill_pos] = 1'b1;
      if (fill_pos + 1 >= cols) fill_pos = '0;
      else fill_pos = fill_pos + 1'b1;
    end else begin
      prod      = value * vec_mem[col_pos];
      prod_wide = prod;
      acc_sum   = acc_sum + prod_wide;
      if (col_pos + 1 < cols) begin
        col_pos = col_pos + 1'b1;
      end else begin
        res.row_sum   = acc_sum;
        res.row_index = row_pos;
        res.last_row  = (row_pos + 1 >= rows);
        expected_rows.push_back(res);
        acc_sum = '0;
        col_pos = '0;
        row_pos = res.last_row ? '0 : row_pos + 1'b1;
      end
    end
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic signed [VALUE_BITS-1:0] v;
    if (extreme_values) begin
      case ($urandom_range(0, 4))
        0:       v = MOST_NEGATIVE;
        1:       v = MOST_POSITIVE;
        2:       v = '0;
        3:       v = -1;
        default: v = 1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Register write while the block is idle
  task automatic write_register(input logic [CFG_IDX_BITS-1:0]  idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ROW_COUNT) rows_reg = data;
    else if (idx == REG_COL_COUNT) cols_reg = data[COLS_REG_BITS-1:0];
  endtask

  // Drive one input beat, after a random gap when idle_on is set, and wait for it to be taken
  task automatic send_beat(input logic kind, input logic signed [VALUE_BITS-1:0] value);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.kind  = kind;
    in_bus.value = value;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    predict_item(kind, value);
  endtask

  // Matrix element; loads the vector first if its column is still empty
  task automatic send_element(input logic signed [VALUE_BITS-1:0] value);
    while (!vec_loaded[col_pos]) send_beat(KIND_VECTOR, pick_value());
    send_beat(KIND_MATRIX, value);
  endtask

  // Load the next column if needed, stop the stream and let the block drain
  task automatic wait_idle();
    while (!vec_loaded[col_pos]) send_beat(KIND_VECTOR, pick_value());
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset counts are one row by one column: every element ends a row
  task automatic test_reset_counts();
    idle_on = 1'b1;
    send_beat(KIND_VECTOR, MOST_NEGATIVE);
    send_beat(KIND_MATRIX, MOST_NEGATIVE);
    send_beat(KIND_MATRIX, MOST_POSITIVE);
    send_beat(KIND_VECTOR, MOST_POSITIVE);
    send_beat(KIND_MATRIX, MOST_POSITIVE);
    send_beat(KIND_MATRIX, '0);
  endtask

  task automatic test_zero_counts();
    wait_idle();
    write_register(REG_ROW_COUNT, '0);
    write_register(REG_COL_COUNT, '0);
    send_beat(KIND_VECTOR, -1);
    send_beat(KIND_MATRIX, 1);
    send_beat(KIND_MATRIX, MOST_NEGATIVE);
  endtask

  // A vector beat inside a row must not disturb the row sum
  task automatic test_vector_load_mid_row();
    wait_idle();
    write_register(REG_ROW_COUNT, 2);
    write_register(REG_COL_COUNT, 3);
    send_beat(KIND_VECTOR, 16'sd4096);
    send_beat(KIND_VECTOR, -16'sd4096);
    send_beat(KIND_VECTOR, 16'sd12345);
    send_element(16'sd4096);
    send_beat(KIND_VECTOR, 16'sd7);
    send_element(-16'sd300);
    send_element(MOST_POSITIVE);
    repeat (3) send_element(pick_value());
  endtask

  // Counts beyond the limits saturate; leave the row partway done
  task automatic test_saturated_counts();
    wait_idle();
    write_register(REG_ROW_COUNT, ROWS_REG_MAX);
    write_register(REG_COL_COUNT, COLS_REG_MAX);
    repeat (3) send_element(pick_value());
  endtask

  // Shrinking counts under a position makes it the last one
  task automatic test_count_change_mid_row();
    wait_idle();
    write_register(REG_COL_COUNT, 2);
    send_element(MOST_NEGATIVE);
    wait_idle();
    write_register(REG_ROW_COUNT, 1);
    repeat (4) send_element(pick_value());
  endtask

  // Long rows at full scale: large sums of both signs
  task automatic test_full_width_row();
    wait_idle();
    write_register(REG_COL_COUNT, WIDE_COLS);
    write_register(REG_ROW_COUNT, 2);
    repeat (WIDE_COLS + 1) send_beat(KIND_VECTOR, MOST_NEGATIVE);
    repeat (WIDE_COLS) send_element(MOST_NEGATIVE);
    repeat (WIDE_COLS) send_element(MOST_POSITIVE);
  endtask

  // One random phase: new counts, an optional vector load, then rows
  task automatic run_random_phase();
    int unsigned rows_pick;
    int unsigned cols_pick;
    int unsigned cols_eff;
    int unsigned n_elems;
    wait_idle();
    idle_on        = ($urandom_range(0, 3) != 0);
    extreme_values = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 19))
      0:          cols_pick = 0;
      1:          cols_pick = 1;
      2, 3, 4, 5: cols_pick = $urandom_range(9, 32);
      default:    cols_pick = $urandom_range(2, 8);
    endcase
    case ($urandom_range(0, 9))
      0:       rows_pick = 0;
      1:       rows_pick = MAX_ROWS;
      2:       rows_pick = ROWS_REG_MAX;
      default: rows_pick = $urandom_range(1, 6);
    endcase
    if ($urandom_range(0, 3) != 0) begin
      write_register(REG_ROW_COUNT, rows_pick);
      write_register(REG_COL_COUNT, cols_pick);
    end else if ($urandom_range(0, 1) != 0) begin
      write_register(REG_ROW_COUNT, rows_pick);
    end else begin
      write_register(REG_COL_COUNT, cols_pick);
    end
    cols_eff = effective_count(cols_reg, MAX_COLS);
    if ($urandom_range(0, 3) != 0) begin
      repeat (cols_eff + 1) send_beat(KIND_VECTOR, pick_value());
    end
    n_elems = cols_eff * ((cols_eff > 32) ? 1 : $urandom_range(1, 4));
    // sometimes stop partway through a row
    if ($urandom_range(0, 3) == 0) n_elems += $urandom_range(0, cols_eff - 1);
    repeat (n_elems) begin
      if ($urandom_range(0, 9) == 0) send_beat(KIND_VECTOR, pick_value());
      send_element(pick_value());
    end
  endtask

  task automatic test_random_phases();
    int unsigned start_count;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) run_random_phase();
  endtask

  // Run the row index through a short row count and its wrap
  task automatic test_row_index_wrap();
    wait_idle();
    idle_on        = 1'b1;
    extreme_values = 1'b0;
    write_register(REG_ROW_COUNT, WRAP_ROWS);
    write_register(REG_COL_COUNT, 1);
    repeat (2 * WRAP_ROWS + 1) send_element(pick_value());
  endtask

  // Result ready: random hold after each taken beat when idle_on is set
  initial begin : result_ready_driver
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (result_hold > 0) begin
        out_bus.ready = 1'b0;
        result_hold--;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  initial begin : result_checker
    row_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        result_hold = idle_on ? $urandom_range(0, 4) : 0;
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected result row_sum %0d row_index %0d last_row %0b",
                   $time, out_bus.row_sum, out_bus.row_index, out_bus.last_row);
          error_count++;
        end else begin
          want = expected_rows.pop_front();
          if (out_bus.row_sum !== want.row_sum) begin
            $display("%0t: row_sum expected %0d, actual %0d",
                     $time, want.row_sum, out_bus.row_sum);
            error_count++;
          end
          if (out_bus.row_index !== want.row_index) begin
            $display("%0t: row_index expected %0d, actual %0d",
                     $time, want.row_index, out_bus.row_index);
            error_count++;
          end
          if (out_bus.last_row !== want.last_row) begin
            $display("%0t: last_row expected %0b, actual %0b",
                     $time, want.last_row, out_bus.last_row);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat on either stream
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) stalled = 0;
      else stalled++;
    end
    $display("matrix_vector_multiply: mismatch");
    $finish;
  end

  // Main sequence
  initial begin : test_sequence
    cfg_we         = 1'b0;
    cfg_idx        = REG_ROW_COUNT;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.kind    = KIND_VECTOR;
    in_bus.value   = '0;
    rst_n          = 1'b0;
    idle_on        = 1'b1;
    extreme_values = 1'b0;
    result_hold    = 0;
    error_count    = 0;
    items_sent     = 0;
    fill_pos       = '0;
    col_pos        = '0;
    row_pos        = '0;
    acc_sum        = '0;
    rows_reg       = 1;
    cols_reg       = 1;
    foreach (vec_loaded[i]) vec_loaded[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_counts();
    test_zero_counts();
    test_vector_load_mid_row();
    test_saturated_counts();
    test_count_change_mid_row();
    test_full_width_row();
    test_random_phases();
    test_row_index_wrap();
    wait_idle();

    if (error_count == 0) begin
      $display("matrix_vector_multiply: match");
    end else begin
      $display("matrix_vector_multiply: mismatch");
    end
    $finish;
  end

endmodule
